// ----- hw/rtl/ffha_pkg.sv -----
// shared constants, codes and types for the first-fit heap allocator
// no dependencies
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 256;
    localparam int MAX_PAGES      = 4096;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = 12;
    localparam int HEADER_BYTES   = 24;
    localparam int INIT_PAGES     = 16;
    localparam int MIN_ALIGN      = 16;
    localparam int MIN_SPLIT      = 32;

    localparam int OFF_W  = 25;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 9;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_STATS = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_MEM    = 3'd1;
    localparam logic [2:0] ST_TBL_FULL  = 3'd2;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic slot_set;
        logic slot_clr;
    } t_tbl_ctrl;

endpackage

`default_nettype wire

// ----- hw/rtl/ffha_table.sv -----
// block table: entry memory with registered read and the slot occupancy bits
// depends on ffha_pkg
`default_nettype none

module ffha_table #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int EW         = 60
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ffha_pkg::t_tbl_ctrl          i_ctrl,
    input  wire [$clog2(MAX_BLOCKS)-1:0] i_rd_idx,
    input  wire [$clog2(MAX_BLOCKS)-1:0] i_wr_idx,
    input  wire [EW-1:0]                 i_wr_data,
    input  wire [$clog2(MAX_BLOCKS)-1:0] i_clr_idx,
    input  wire [$clog2(MAX_BLOCKS)-1:0] i_scan_idx,
    output logic [EW-1:0]                o_rd_data,
    output logic                         o_scan_busy
);
    import ffha_pkg::*;

    logic [EW-1:0]         mem [MAX_BLOCKS];
    logic [EW-1:0]         r_rd;
    logic [MAX_BLOCKS-1:0] r_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            if (i_ctrl.slot_set) begin
                r_slot[i_wr_idx] <= 1'b1;
            end
            if (i_ctrl.slot_clr) begin
                r_slot[i_clr_idx] <= 1'b0;
            end
        end
    end

    assign o_rd_data   = r_rd;
    assign o_scan_busy = r_slot[i_scan_idx];

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// first-fit heap allocator: command sequencer, block list walks and result register
// depends on ffha_pkg and ffha_table
// Each command is one item and gives one result item. Commands are taken one at a
// time and the block list lives in a single table memory read once per step, so the
// cost follows the list length: stats reads every block, free walks the blocks up to
// the match, then each merged successor and then the predecessor walk from the head;
// allocate visits blocks in turn, plus a slot search (up to MAX_BLOCKS slots) when a
// block is split or the heap grows, plus a walk to the list tail on each growth.
// Slot occupancy is held in flip-flops cleared by reset, so no clearing pass is
// needed. A finished result waits in the output register; the next item is taken once
// the sequencer is back to idle.
`default_nettype none

module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire [47:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_cmd,
    input  wire [31:0]  i_req_size,
    input  wire [12:0]  i_req_align,
    input  wire [47:0]  i_free_addr,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_status,
    output logic [47:0] o_granted_addr,
    output logic [8:0]  o_block_total,
    output logic [8:0]  o_free_block_total,
    output logic [8:0]  o_used_block_total,
    output logic [24:0] o_free_byte_total,
    output logic [24:0] o_used_byte_total,
    output logic [24:0] o_largest_free,
    output logic [24:0] o_heap_span
);
    import ffha_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 2 * OFF_W + 1 + LW;
    localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DONE     = 5'd1;
    localparam logic [4:0] S_GROW_CHK = 5'd2;
    localparam logic [4:0] S_SCAN     = 5'd3;
    localparam logic [4:0] S_GROW_WR  = 5'd4;
    localparam logic [4:0] S_GW_RD    = 5'd5;
    localparam logic [4:0] S_GW_CK    = 5'd6;
    localparam logic [4:0] S_GW_WR    = 5'd7;
    localparam logic [4:0] S_GROW_END = 5'd8;
    localparam logic [4:0] S_FIT_RD   = 5'd9;
    localparam logic [4:0] S_FIT_A    = 5'd10;
    localparam logic [4:0] S_FIT_B    = 5'd11;
    localparam logic [4:0] S_FIT_C    = 5'd12;
    localparam logic [4:0] S_FIT_D    = 5'd13;
    localparam logic [4:0] S_SPL_WR_N = 5'd14;
    localparam logic [4:0] S_SPL_WR_B = 5'd15;
    localparam logic [4:0] S_FR_RD    = 5'd16;
    localparam logic [4:0] S_FR_A     = 5'd17;
    localparam logic [4:0] S_FR_B     = 5'd18;
    localparam logic [4:0] S_FS_RD    = 5'd19;
    localparam logic [4:0] S_FS_CK    = 5'd20;
    localparam logic [4:0] S_FB_WR    = 5'd21;
    localparam logic [4:0] S_FP_RD    = 5'd22;
    localparam logic [4:0] S_FP_CK    = 5'd23;
    localparam logic [4:0] S_ST_RD    = 5'd24;
    localparam logic [4:0] S_ST_CK    = 5'd25;

    logic [4:0]        r_state;
    logic [47:0]       r_heap_base;
    logic [12:0]       r_page_limit;
    logic [LW-1:0]     r_head;
    logic [12:0]       r_pages;

    logic [1:0]        r_cmd;
    logic [31:0]       r_size;
    logic [12:0]       r_align;
    logic [47:0]       r_addr;

    logic [LW-1:0]     r_b;
    logic [LW-1:0]     r_t;
    logic [LW-1:0]     r_steps;
    logic [LW-1:0]     r_s2;
    logic [1:0]        r_try;
    logic [21:0]       r_grow_pages;
    logic [AW-1:0]     r_scan;
    logic [AW-1:0]     r_new;
    logic              r_scan_split;

    logic [OFF_W-1:0]  r_e_off;
    logic [OFF_W-1:0]  r_e_pay;
    logic              r_e_free;
    logic [LW-1:0]     r_e_link;
    logic [OFF_W-1:0]  r_x_off;
    logic [OFF_W-1:0]  r_x_pay;
    logic              r_x_free;

    logic [49:0]       r_p;
    logic [49:0]       r_al;
    logic [49:0]       r_bend;
    logic [49:0]       r_uend;
    logic              r_hit;

    logic [2:0]        r_res_status;
    logic [47:0]       r_res_addr;
    logic [8:0]        r_res_blocks;
    logic [8:0]        r_res_free_blocks;
    logic [8:0]        r_res_used_blocks;
    logic [24:0]       r_res_free_bytes;
    logic [24:0]       r_res_used_bytes;
    logic [24:0]       r_res_largest;
    logic [24:0]       r_res_span;

    logic              r_o_valid;
    logic [2:0]        r_o_status;
    logic [47:0]       r_o_addr;
    logic [8:0]        r_o_blocks;
    logic [8:0]        r_o_free_blocks;
    logic [8:0]        r_o_used_blocks;
    logic [24:0]       r_o_free_bytes;
    logic [24:0]       r_o_used_bytes;
    logic [24:0]       r_o_largest;
    logic [24:0]       r_o_span;

    t_tbl_ctrl         tbl_ctrl;
    logic [AW-1:0]     tbl_rd_idx;
    logic [AW-1:0]     tbl_wr_idx;
    logic [EW-1:0]     tbl_wr_data;
    logic [AW-1:0]     tbl_clr_idx;
    logic [EW-1:0]     rd_data;
    logic              scan_busy;

    logic [OFF_W-1:0]  rd_off;
    logic [OFF_W-1:0]  rd_pay;
    logic              rd_free;
    logic [LW-1:0]     rd_link;

    logic [49:0]       base50;
    logic [12:0]       a_m1;
    logic [12:0]       pad;
    logic [33:0]       grow_bytes;
    logic [12:0]       limit;
    logic [49:0]       fr_end;
    logic              fr_hit;
    logic              b_ok;
    logic              t_ok;
    logic              succ_adj;
    logic              pred_adj;
    logic              do_load;

    assign rd_off  = rd_data[EW-1 -: OFF_W];
    assign rd_pay  = rd_data[EW-OFF_W-1 -: OFF_W];
    assign rd_free = rd_data[LW];
    assign rd_link = rd_data[LW-1:0];

    assign base50     = {2'b00, r_heap_base[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign a_m1       = r_align - 13'd1;
    assign pad        = r_al[12:0] - r_p[12:0];
    assign grow_bytes = 34'(r_size) + 34'(r_align) + 34'(HEADER_BYTES + PAGE_BYTES - 1);
    assign limit      = (r_page_limit < 13'(MAX_PAGES)) ? r_page_limit : 13'(MAX_PAGES);
    assign fr_end     = r_p + 50'(r_e_pay);
    assign fr_hit     = ({2'b00, r_addr} >= r_p) && ({2'b00, r_addr} < fr_end);
    assign b_ok       = (r_b < NIL) && (r_steps < LW'(MAX_BLOCKS));
    assign t_ok       = (r_t < NIL) && (r_s2 < LW'(MAX_BLOCKS));
    assign succ_adj   = (26'(r_e_off) + 26'(HEADER_BYTES) + 26'(r_e_pay)) == 26'(rd_off);
    assign pred_adj   = (26'(rd_off) + 26'(HEADER_BYTES) + 26'(rd_pay)) == 26'(r_e_off);
    assign do_load    = (r_state == S_DONE) && (!r_o_valid || i_ready);

    always_comb begin
        tbl_ctrl    = '0;
        tbl_rd_idx  = r_b[AW-1:0];
        tbl_wr_idx  = r_b[AW-1:0];
        tbl_wr_data = {r_e_off, r_e_pay, r_e_free, r_e_link};
        tbl_clr_idx = r_t[AW-1:0];
        unique case (r_state)
            S_GROW_WR: begin
                tbl_ctrl.wr_en    = 1'b1;
                tbl_ctrl.slot_set = 1'b1;
                tbl_wr_idx        = r_new;
                tbl_wr_data       = {{r_pages, {PAGE_SHIFT{1'b0}}},
                                     OFF_W'({r_grow_pages[12:0], {PAGE_SHIFT{1'b0}}}
                                            - 25'(HEADER_BYTES)),
                                     1'b1, NIL};
            end
            S_GW_RD: begin
                tbl_ctrl.rd_en = 1'b1;
                tbl_rd_idx     = r_t[AW-1:0];
            end
            S_GW_WR: begin
                tbl_ctrl.wr_en = 1'b1;
                tbl_wr_idx     = r_t[AW-1:0];
                tbl_wr_data    = {r_x_off, r_x_pay, r_x_free, LW'(r_new)};
            end
            S_FIT_RD, S_FR_RD, S_ST_RD: begin
                tbl_ctrl.rd_en = b_ok;
            end
            S_SPL_WR_N: begin
                tbl_ctrl.wr_en    = 1'b1;
                tbl_ctrl.slot_set = 1'b1;
                tbl_wr_idx        = r_new;
                tbl_wr_data       = {OFF_W'(r_uend - base50),
                                     OFF_W'(r_bend - r_uend - 50'(HEADER_BYTES)),
                                     1'b1, r_e_link};
            end
            S_SPL_WR_B: begin
                tbl_ctrl.wr_en = 1'b1;
                tbl_wr_data    = {r_e_off, r_e_pay, 1'b0, r_e_link};
            end
            S_FS_RD, S_FP_RD: begin
                tbl_ctrl.rd_en = t_ok;
                tbl_rd_idx     = r_t[AW-1:0];
            end
            S_FS_CK: begin
                tbl_ctrl.slot_clr = rd_free && succ_adj;
            end
            S_FB_WR: begin
                tbl_ctrl.wr_en = 1'b1;
                tbl_wr_data    = {r_e_off, r_e_pay, 1'b1, r_e_link};
            end
            S_FP_CK: begin
                if ((rd_link < NIL) && (rd_link == r_b) && rd_free && pred_adj) begin
                    tbl_ctrl.wr_en    = 1'b1;
                    tbl_ctrl.slot_clr = 1'b1;
                end
                tbl_wr_idx  = r_t[AW-1:0];
                tbl_clr_idx = r_b[AW-1:0];
                tbl_wr_data = {rd_off, OFF_W'(26'(rd_pay) + 26'(HEADER_BYTES) + 26'(r_e_pay)),
                               rd_free, r_e_link};
            end
            default: begin
            end
        endcase
    end

    ffha_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .EW         (EW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (tbl_ctrl),
        .i_rd_idx    (tbl_rd_idx),
        .i_wr_idx    (tbl_wr_idx),
        .i_wr_data   (tbl_wr_data),
        .i_clr_idx   (tbl_clr_idx),
        .i_scan_idx  (r_scan),
        .o_rd_data   (rd_data),
        .o_scan_busy (scan_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_base  <= '0;
            r_page_limit <= 13'(MAX_PAGES);
            r_head       <= NIL;
            r_pages      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                    CFG_PAGE_LIMIT: r_page_limit <= i_cfg_data[12:0];
                endcase
            end
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (do_load) begin
                r_o_valid <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd             <= i_cmd;
                        r_size            <= i_req_size;
                        r_align           <= (i_req_align < 13'(MIN_ALIGN)) ?
                                             13'(MIN_ALIGN) : i_req_align;
                        r_addr            <= i_free_addr;
                        r_res_status      <= ST_OK;
                        r_res_addr        <= '0;
                        r_res_blocks      <= '0;
                        r_res_free_blocks <= '0;
                        r_res_used_blocks <= '0;
                        r_res_free_bytes  <= '0;
                        r_res_used_bytes  <= '0;
                        r_res_largest     <= '0;
                        r_res_span        <= '0;
                        r_b               <= r_head;
                        r_steps           <= '0;
                        r_try             <= '0;
                        unique case (i_cmd)
                            CMD_INIT: begin
                                if (r_head < NIL) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_grow_pages <= 22'(INIT_PAGES);
                                    r_state      <= S_GROW_CHK;
                                end
                            end
                            CMD_ALLOC: begin
                                if (i_req_size == '0) begin
                                    r_res_status <= ST_ZERO_SIZE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_FIT_RD;
                                end
                            end
                            CMD_FREE: begin
                                r_state <= (i_free_addr == '0) ? S_DONE : S_FR_RD;
                            end
                            CMD_STATS: begin
                                r_state <= S_ST_RD;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (do_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_GROW_CHK: begin
                    if ((23'(r_pages) + 23'(r_grow_pages)) > 23'(limit)) begin
                        r_res_status <= ST_NO_MEM;
                        r_state      <= S_DONE;
                    end else begin
                        r_scan       <= '0;
                        r_scan_split <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!scan_busy) begin
                        r_new   <= r_scan;
                        r_state <= r_scan_split ? S_SPL_WR_N : S_GROW_WR;
                    end else if (r_scan == AW'(MAX_BLOCKS - 1)) begin
                        if (r_scan_split) begin
                            r_state <= S_SPL_WR_B;
                        end else begin
                            r_res_status <= ST_TBL_FULL;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_scan <= r_scan + AW'(1);
                    end
                end
                S_GROW_WR: begin
                    if (r_head < NIL) begin
                        r_t     <= r_head;
                        r_s2    <= '0;
                        r_state <= S_GW_RD;
                    end else begin
                        r_head  <= LW'(r_new);
                        r_state <= S_GROW_END;
                    end
                end
                S_GW_RD: begin
                    r_state <= S_GW_CK;
                end
                S_GW_CK: begin
                    r_x_off  <= rd_off;
                    r_x_pay  <= rd_pay;
                    r_x_free <= rd_free;
                    if ((rd_link < NIL) && (r_s2 < LW'(MAX_BLOCKS))) begin
                        r_t     <= rd_link;
                        r_s2    <= r_s2 + LW'(1);
                        r_state <= S_GW_RD;
                    end else begin
                        r_state <= S_GW_WR;
                    end
                end
                S_GW_WR: begin
                    r_state <= S_GROW_END;
                end
                S_GROW_END: begin
                    r_pages <= r_pages + r_grow_pages[12:0];
                    if (r_cmd == CMD_ALLOC) begin
                        r_try   <= r_try + 2'd1;
                        r_b     <= r_head;
                        r_steps <= '0;
                        r_state <= S_FIT_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FIT_RD: begin
                    if (b_ok) begin
                        r_state <= S_FIT_A;
                    end else if (r_try == 2'd2) begin
                        r_res_status <= ST_NO_MEM;
                        r_state      <= S_DONE;
                    end else begin
                        r_grow_pages <= grow_bytes[33:PAGE_SHIFT];
                        r_state      <= S_GROW_CHK;
                    end
                end
                S_FIT_A: begin
                    r_e_off  <= rd_off;
                    r_e_pay  <= rd_pay;
                    r_e_free <= rd_free;
                    r_e_link <= rd_link;
                    r_p      <= base50 + 50'(rd_off) + 50'(HEADER_BYTES);
                    r_state  <= S_FIT_B;
                end
                S_FIT_B: begin
                    r_al    <= (r_p + 50'(a_m1)) & ~50'(a_m1);
                    r_bend  <= r_p + 50'(r_e_pay);
                    r_state <= S_FIT_C;
                end
                S_FIT_C: begin
                    r_uend  <= r_al + 50'(r_size);
                    r_hit   <= r_e_free && (33'(r_e_pay) >= (33'(r_size) + 33'(pad)));
                    r_state <= S_FIT_D;
                end
                S_FIT_D: begin
                    if (r_hit) begin
                        r_res_addr <= r_al[47:0];
                        if (r_bend > (r_uend + 50'(HEADER_BYTES + MIN_SPLIT))) begin
                            r_scan       <= '0;
                            r_scan_split <= 1'b1;
                            r_state      <= S_SCAN;
                        end else begin
                            r_state <= S_SPL_WR_B;
                        end
                    end else begin
                        r_b     <= r_e_link;
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_FIT_RD;
                    end
                end
                S_SPL_WR_N: begin
                    r_e_link <= LW'(r_new);
                    r_e_pay  <= OFF_W'(r_uend - r_p);
                    r_state  <= S_SPL_WR_B;
                end
                S_SPL_WR_B: begin
                    r_state <= S_DONE;
                end
                S_FR_RD: begin
                    if (b_ok) begin
                        r_state <= S_FR_A;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end
                end
                S_FR_A: begin
                    r_e_off  <= rd_off;
                    r_e_pay  <= rd_pay;
                    r_e_free <= rd_free;
                    r_e_link <= rd_link;
                    r_p      <= base50 + 50'(rd_off) + 50'(HEADER_BYTES);
                    r_state  <= S_FR_B;
                end
                S_FR_B: begin
                    if (fr_hit) begin
                        r_e_free <= 1'b1;
                        r_t      <= r_e_link;
                        r_s2     <= '0;
                        r_state  <= S_FS_RD;
                    end else begin
                        r_b     <= r_e_link;
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_FR_RD;
                    end
                end
                S_FS_RD: begin
                    r_state <= t_ok ? S_FS_CK : S_FB_WR;
                end
                S_FS_CK: begin
                    if (rd_free && succ_adj) begin
                        r_e_pay  <= OFF_W'(26'(r_e_pay) + 26'(HEADER_BYTES) + 26'(rd_pay));
                        r_e_link <= rd_link;
                        r_t      <= rd_link;
                        r_s2     <= r_s2 + LW'(1);
                        r_state  <= S_FS_RD;
                    end else begin
                        r_state <= S_FB_WR;
                    end
                end
                S_FB_WR: begin
                    r_t     <= r_head;
                    r_s2    <= '0;
                    r_state <= S_FP_RD;
                end
                S_FP_RD: begin
                    r_state <= t_ok ? S_FP_CK : S_DONE;
                end
                S_FP_CK: begin
                    if (!(rd_link < NIL) || ((rd_link == r_b) && rd_free)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_t     <= rd_link;
                        r_s2    <= r_s2 + LW'(1);
                        r_state <= S_FP_RD;
                    end
                end
                S_ST_RD: begin
                    if (b_ok) begin
                        r_state <= S_ST_CK;
                    end else begin
                        r_res_span <= {r_pages, {PAGE_SHIFT{1'b0}}};
                        r_state    <= S_DONE;
                    end
                end
                S_ST_CK: begin
                    r_res_blocks <= r_res_blocks + 9'd1;
                    if (rd_free) begin
                        r_res_free_blocks <= r_res_free_blocks + 9'd1;
                        r_res_free_bytes  <= r_res_free_bytes + rd_pay;
                        if (rd_pay > r_res_largest) begin
                            r_res_largest <= rd_pay;
                        end
                    end else begin
                        r_res_used_blocks <= r_res_used_blocks + 9'd1;
                        r_res_used_bytes  <= r_res_used_bytes + rd_pay;
                    end
                    r_b     <= rd_link;
                    r_steps <= r_steps + LW'(1);
                    r_state <= S_ST_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_o_status      <= r_res_status;
            r_o_addr        <= (r_res_status == ST_OK) ? r_res_addr : '0;
            r_o_blocks      <= r_res_blocks;
            r_o_free_blocks <= r_res_free_blocks;
            r_o_used_blocks <= r_res_used_blocks;
            r_o_free_bytes  <= r_res_free_bytes;
            r_o_used_bytes  <= r_res_used_bytes;
            r_o_largest     <= r_res_largest;
            r_o_span        <= r_res_span;
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_granted_addr     = r_o_addr;
    assign o_block_total      = r_o_blocks;
    assign o_free_block_total = r_o_free_blocks;
    assign o_used_block_total = r_o_used_blocks;
    assign o_free_byte_total  = r_o_free_bytes;
    assign o_used_byte_total  = r_o_used_bytes;
    assign o_largest_free     = r_o_largest;
    assign o_heap_span        = r_o_span;

`ifndef ASSERT_OFF
    a_empty_list_no_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NIL) |-> (r_pages == '0))
        else $error("empty block list with pages mapped");
    a_pages_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= 13'(MAX_PAGES))
        else $error("mapped pages beyond limit");
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_ctrl.rd_en && tbl_ctrl.wr_en))
        else $error("table read and write in the same cycle");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted item left sequencer idle");
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |=> r_o_valid)
        else $error("pending result dropped");
`endif

endmodule

`default_nettype wire
